### sv/assert_macros.svh
// Assertion macros used by the allocator core.
// Depends on a clock named clock and an active-high reset named reset in the user module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define DSA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// An expression that must never be true outside reset.
`define DSA_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

### sv/dsa_pkg.sv
// Shared types and constants of the descriptor slot allocator.
// No dependencies; imported by the row unit, the busy-mark memory and the top level.
`default_nettype none

package dsa_pkg;

   // Busy marks are stored and examined one row of sixteen slots at a time.
   localparam int ROW_W    = 16;
   localparam int ROW_BITS = 4;

   // Operation codes carried in the request tuser.
   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Result status codes carried in the response tuser.
   localparam logic [1:0] ST_GRANT  = 2'd0;
   localparam logic [1:0] ST_FREED  = 2'd1;
   localparam logic [1:0] ST_NOROOM = 2'd2;
   localparam logic [1:0] ST_BADREL = 2'd3;

   // Register index of active_slots, taken from byte address bit 2.
   localparam logic CSR_IDX_ACTIVE = 1'b0;

   // Sequencer states.
   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_ALLOC  = 6'b000010,
      S_NOROOM = 6'b000100,
      S_REL    = 6'b001000,
      S_RC_RD  = 6'b010000,
      S_RC_ACC = 6'b100000
   } state_type;

   // Outcome of examining one row of busy marks.
   typedef struct packed {
      logic                found;
      logic [ROW_BITS-1:0] bit_idx;
      logic [ROW_W-1:0]    onehot;
      logic [ROW_BITS:0]   busy_cnt;
   } row_res_type;

   // Control of the busy-mark memory for one cycle.
   typedef struct packed {
      logic             rd_en;
      logic             wr_en;
      logic [ROW_W-1:0] wr_data;
   } mem_req_type;

endpackage

`default_nettype wire

### sv/dsa_row_unit.sv
// Shared row unit: finds the lowest free live slot in a row and counts its live busy slots.
// Depends on dsa_pkg.
`default_nettype none

module dsa_row_unit
   import dsa_pkg::*;
#(
   parameter int RW = 5
) (
   input  wire logic [ROW_W-1:0] row_data,
   input  wire logic [RW-1:0]    row_idx,
   input  wire logic [8:0]       live_n,
   output row_res_type           res
);

   logic [ROW_W-1:0]    live;
   logic [ROW_W-1:0]    free_bits;
   logic [ROW_BITS-1:0] idx;
   logic [ROW_BITS:0]   cnt;
   logic [RW+ROW_BITS-1:0] slot_num;

   // A slot is live when its number lies below the active size.
   always_comb begin
      for (int j = 0; j < ROW_W; j++) begin
         slot_num = {row_idx, ROW_BITS'(j)};
         live[j] = (32'(slot_num) < 32'(live_n));
      end
   end

   assign free_bits = live & ~row_data;

   // Priority encoder: the lowest free bit wins.
   always_comb begin
      idx = '0;
      for (int j = ROW_W - 1; j >= 0; j--) begin
         if (free_bits[j]) begin
            idx = ROW_BITS'(j);
         end
      end
   end

   // Population count of live busy marks.
   always_comb begin
      cnt = '0;
      for (int j = 0; j < ROW_W; j++) begin
         cnt = cnt + (ROW_BITS + 1)'(live[j] & row_data[j]);
      end
   end

   assign res.found    = |free_bits;
   assign res.bit_idx  = idx;
   assign res.onehot   = (|free_bits) ? (ROW_W'(1) << idx) : '0;
   assign res.busy_cnt = cnt;

endmodule

`default_nettype wire

### sv/dsa_busy_mem.sv
// Busy-mark memory: one row of sixteen marks per entry, registered read, row valid bits.
// Depends on dsa_pkg. A row never written since reset reads as all free.
`default_nettype none

module dsa_busy_mem
   import dsa_pkg::*;
#(
   parameter int ROWS = 16,
   parameter int RW   = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire mem_req_type      req,
   input  wire logic [RW-1:0]    wr_addr,
   input  wire logic [RW-1:0]    rd_addr,
   output logic      [ROW_W-1:0] rd_data
);

   logic [ROW_W-1:0] mem [ROWS];
   logic [ROWS-1:0]  valid_ff;
   logic [ROW_W-1:0] rdata_ff;
   logic             rvalid_ff;

   // Row valid bits, cleared together at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (req.wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   // Storage write and registered read.
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rdata_ff  <= mem[rd_addr];
         rvalid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rvalid_ff ? rdata_ff : '0;

endmodule

`default_nettype wire

### sv/descriptor_slot_allocator_core.sv
// Descriptor slot allocator: sequencer around a shared row unit and a busy-mark memory.
// Allocate reads row 0 and grants row by row; a release reads its row, then answers; refusals go via S_NOROOM.
// One grant leaves per cycle while the response side takes them; the row scan sets the figure.
// A write to active_slots starts a recount that reads each row and sums its live busy marks in turn.
// Synchronous active-high reset: every slot free, active_slots 256, no response pending.
`default_nettype none

module descriptor_slot_allocator_core
   import dsa_pkg::*;
#(
   parameter int SLOT_COUNT = 256,
   parameter int MAX_BATCH  = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [4:0] count, [12:5] slot_index, zero above
   input  wire logic [0:0]  req_tuser,   // [0] op
   // Response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [23:0] rsp_tdata,   // [7:0] granted_index, [16:8] free_slots, zero above
   output logic      [1:0]  rsp_tuser,   // [1:0] status
   output logic             rsp_tlast,
   // Register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   `include "assert_macros.svh"

   localparam int LIVE_MAX   = (SLOT_COUNT < 511) ? SLOT_COUNT : 511;
   localparam int MEM_ROWS   = (LIVE_MAX + ROW_W - 1) / ROW_W;
   localparam int RW         = (MEM_ROWS > 1) ? $clog2(MEM_ROWS) : 1;
   localparam int RESET_FREE = (SLOT_COUNT < 256) ? SLOT_COUNT : 256;

   state_type        state_ff, state_in;
   logic [4:0]       count_ff, count_in;
   logic [7:0]       slot_ff, slot_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [4:0]       grants_ff, grants_in;
   logic [ROW_W-1:0] work_row_ff, work_row_in;
   logic             load_ff, load_in;
   logic [8:0]       free_ff, free_in;
   logic [9:0]       acc_ff, acc_in;
   logic [8:0]       active_ff, active_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;
   logic [7:0]       rsp_index_ff, rsp_index_in;
   logic [8:0]       rsp_free_ff, rsp_free_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             req_accept;
   logic             cfg_wr;
   logic             out_free;
   logic [8:0]       live_n;
   logic [ROW_W-1:0] mem_rdata;
   logic [ROW_W-1:0] cur_row;
   logic [RW-1:0]    rd_addr;
   logic [RW-1:0]    wr_addr;
   mem_req_type      mem_req;
   row_res_type      res;
   logic             emit;
   logic             emit_grant;
   logic [1:0]       emit_status;
   logic [7:0]       emit_index;
   logic [8:0]       emit_free;
   logic             emit_last;
   logic [9:0]       slot_full;
   logic [9:0]       acc_new;
   logic             alloc_bad;
   logic             rel_bad;
   logic             last_row;
   logic [15:0]      grant_wide;

   // Active size is the register clamped to the table.
   assign live_n = (32'(active_ff) > LIVE_MAX) ? 9'(LIVE_MAX) : active_ff;

   assign req_accept = req_tvalid && req_tready;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == CSR_IDX_ACTIVE);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign cur_row    = load_ff ? mem_rdata : work_row_ff;
   assign slot_full  = 10'({row_ff, res.bit_idx});
   assign grant_wide = 16'({row_ff, res.bit_idx});
   assign acc_new    = acc_ff + 10'(res.busy_cnt);
   assign last_row   = (32'(row_ff) == MEM_ROWS - 1);

   assign alloc_bad = (req_tdata[4:0] == 5'd0) || (32'(req_tdata[4:0]) > MAX_BATCH) ||
                      ({4'd0, req_tdata[4:0]} > free_ff);
   assign rel_bad   = ({1'b0, slot_ff} >= live_n) ||
                      !cur_row[slot_ff[ROW_BITS-1:0]];

   dsa_busy_mem #(
      .ROWS (MEM_ROWS),
      .RW   (RW)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .req     (mem_req),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr),
      .rd_data (mem_rdata)
   );

   dsa_row_unit #(
      .RW (RW)
   ) u_row (
      .row_data (cur_row),
      .row_idx  (row_ff),
      .live_n   (live_n),
      .res      (res)
   );

   // Sequencer: rows of busy marks are examined one at a time by the shared row unit.
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      slot_in     = slot_ff;
      row_in      = row_ff;
      grants_in   = grants_ff;
      work_row_in = work_row_ff;
      load_in     = load_ff;
      free_in     = free_ff;
      acc_in      = acc_ff;
      active_in   = active_ff;
      mem_req     = '0;
      rd_addr     = row_ff;
      wr_addr     = row_ff;
      emit        = 1'b0;
      emit_grant  = 1'b0;
      emit_status = ST_NOROOM;
      emit_index  = 8'd0;
      emit_free   = free_ff;
      emit_last   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               count_in  = req_tdata[4:0];
               slot_in   = req_tdata[12:5];
               grants_in = 5'd0;
               if (req_tuser[0] == OP_RELEASE) begin
                  rd_addr       = RW'(req_tdata[12:5] >> ROW_BITS);
                  row_in        = rd_addr;
                  mem_req.rd_en = 1'b1;
                  load_in       = 1'b1;
                  state_in      = S_REL;
               end else if (alloc_bad) begin
                  state_in = S_NOROOM;
               end else begin
                  rd_addr       = '0;
                  row_in        = '0;
                  mem_req.rd_en = 1'b1;
                  load_in       = 1'b1;
                  state_in      = S_ALLOC;
               end
            end
         end

         S_NOROOM: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end

         S_REL: begin
            if (out_free) begin
               emit = 1'b1;
               if (rel_bad) begin
                  emit_status = ST_BADREL;
               end else begin
                  emit_status     = ST_FREED;
                  emit_free       = free_ff + 9'd1;
                  free_in         = free_ff + 9'd1;
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_data = cur_row & ~(ROW_W'(1) << slot_ff[ROW_BITS-1:0]);
               end
               state_in = S_IDLE;
            end
         end

         S_ALLOC: begin
            if (res.found) begin
               work_row_in = cur_row;
               load_in     = 1'b0;
               if (out_free) begin
                  emit        = 1'b1;
                  emit_grant  = 1'b1;
                  emit_status = ST_GRANT;
                  emit_index  = grant_wide[7:0];
                  emit_free   = free_ff - 9'd1;
                  emit_last   = (5'(grants_ff + 5'd1) == count_ff);
                  free_in     = free_ff - 9'd1;
                  grants_in   = 5'(grants_ff + 5'd1);
                  work_row_in = cur_row | res.onehot;
                  if (emit_last) begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_data = cur_row | res.onehot;
                     state_in        = S_IDLE;
                  end
               end
            end else begin
               // Row exhausted: store it back and fetch the next one.
               mem_req.wr_en   = 1'b1;
               mem_req.wr_data = cur_row;
               rd_addr         = RW'(row_ff + 1'b1);
               row_in          = rd_addr;
               mem_req.rd_en   = 1'b1;
               load_in         = 1'b1;
            end
         end

         S_RC_RD: begin
            mem_req.rd_en = 1'b1;
            load_in       = 1'b1;
            state_in      = S_RC_ACC;
         end

         S_RC_ACC: begin
            if (last_row) begin
               free_in  = live_n - acc_new[8:0];
               state_in = S_IDLE;
            end else begin
               acc_in   = acc_new;
               row_in   = RW'(row_ff + 1'b1);
               state_in = S_RC_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // A size change restarts the free count over the new active part.
      if (cfg_wr) begin
         active_in = csr_pwdata[8:0];
         row_in    = '0;
         acc_in    = '0;
         state_in  = S_RC_RD;
      end
   end

   // Response register: loaded whenever the previous transaction has gone.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_free_in   = rsp_free_ff;
      rsp_last_in   = rsp_last_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = emit_status;
         rsp_index_in  = emit_index;
         rsp_free_in   = emit_free;
         rsp_last_in   = emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         load_ff      <= 1'b0;
         free_ff      <= 9'(RESET_FREE);
         active_ff    <= 9'd256;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_ff      <= load_in;
         free_ff      <= free_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      slot_ff       <= slot_in;
      row_ff        <= row_in;
      grants_ff     <= grants_in;
      work_row_ff   <= work_row_in;
      acc_ff        <= acc_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_free_ff   <= rsp_free_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Port outputs.
   assign req_tready = (state_ff == S_IDLE) && !cfg_wr;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_free_ff, rsp_index_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_ACTIVE) ? {23'd0, active_ff} : 32'd0;

   // Checks on the sequencer.
   `DSA_ASSERT(a_free_in_range, (state_ff == S_IDLE) |-> (free_ff <= live_n), "free count exceeds active size")
   `DSA_ASSERT(a_grant_live, emit_grant |-> (slot_full < {1'b0, live_n}), "granted slot outside active size")
   `DSA_ASSERT(a_run_open, (state_ff == S_ALLOC) |-> (grants_ff < count_ff), "allocate run overran its count")

endmodule

`default_nettype wire

### sim/slot_alloc_checker.sv
// Response checker for the descriptor slot allocator: keeps its own busy marks and size.
// It predicts every response and compares the responses as they are accepted.
// Depends on dsa_pkg for the operation, status and register codes.

module slot_alloc_checker
   import dsa_pkg::*;
#(
   parameter int SLOT_COUNT = 256,
   parameter int MAX_BATCH  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [4:0] count, [12:5] slot_index, zero above
   input  logic [0:0]  req_tuser,   // [0] op
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // [7:0] granted_index, [16:8] free_slots, zero above
   input  logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic        csr_pready,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output int          mismatches,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] index;
      logic [8:0] free;
      logic       last;
   } slot_response_type;

   // Shadow of the busy marks and of the active_slots register.
   bit                slot_taken [SLOT_COUNT];
   logic [8:0]        active_size;
   slot_response_type due_responses [$];
   int                responses_seen;

   initial begin
      mismatches     = 0;
      pending        = 0;
      responses_seen = 0;
   end

   task automatic flag_mismatch(input string what, input int got, input int want);
      mismatches++;
      $display("%0t ns: response %0d %s: got %0d, expected %0d",
               $time, responses_seen, what, got, want);
   endtask

   function automatic void queue_response(input logic [1:0] status, input int index,
                                          input int free, input bit last);
      slot_response_type resp;
      resp.status = status;
      resp.index  = index[7:0];
      resp.free   = free[8:0];
      resp.last   = last;
      due_responses.push_back(resp);
   endfunction

   // Works out the responses to one request and updates the shadow busy marks.
   task automatic allocate_or_release(input logic op, input logic [4:0] cnt,
                                      input logic [7:0] slot);
      int live;
      int free_now;
      int granted;
      live = (active_size > SLOT_COUNT) ? SLOT_COUNT : int'(active_size);
      free_now = live;
      for (int i = 0; i < live; i++) begin
         if (slot_taken[i]) free_now--;
      end
      if (op == OP_ALLOC) begin
         // A count of zero, above the batch limit or above the free count is refused whole.
         if (cnt == 0 || cnt > MAX_BATCH || int'(cnt) > free_now) begin
            queue_response(ST_NOROOM, 0, free_now, 1'b1);
         end else begin
            granted = 0;
            for (int i = 0; i < live && granted < int'(cnt); i++) begin
               if (!slot_taken[i]) begin
                  slot_taken[i] = 1'b1;
                  free_now--;
                  granted++;
                  queue_response(ST_GRANT, i, free_now, granted == int'(cnt));
               end
            end
         end
      end else if (int'(slot) >= live || !slot_taken[slot]) begin
         // Freeing an idle slot, or one outside the active size, changes nothing.
         queue_response(ST_BADREL, 0, free_now, 1'b1);
      end else begin
         slot_taken[slot] = 1'b0;
         queue_response(ST_FREED, 0, free_now + 1, 1'b1);
      end
   endtask

   task automatic check_response();
      slot_response_type want;
      responses_seen++;
      if (due_responses.size() == 0) begin
         flag_mismatch("arrived with nothing outstanding, status", rsp_tuser, 0);
      end else begin
         want = due_responses.pop_front();
         if (rsp_tuser != want.status)
            flag_mismatch("status", rsp_tuser, want.status);
         if (rsp_tdata[7:0] != want.index)
            flag_mismatch("granted_index", rsp_tdata[7:0], want.index);
         if (rsp_tdata[16:8] != want.free)
            flag_mismatch("free_slots", rsp_tdata[16:8], want.free);
         if (rsp_tlast != want.last)
            flag_mismatch("last", rsp_tlast, want.last);
      end
   endtask

   // Responses are compared before the new request is modelled; order on the
   // queue is the same either way since a response never meets its own request.
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) slot_taken[i] = 1'b0;
         active_size = 9'd256;
         due_responses.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_response();
         if (req_tvalid && req_tready)
            allocate_or_release(req_tuser[0], req_tdata[4:0], req_tdata[12:5]);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[2] == CSR_IDX_ACTIVE)
            active_size = csr_pwdata[8:0];
      end
      pending = due_responses.size();
   end

endmodule

### sim/tb_top.sv
// Top of the slot allocator testbench: clock, reset, request and register stimulus, verdict.
// Depends on dsa_pkg, descriptor_slot_allocator_core and slot_alloc_checker.

module tb_top
   import dsa_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] ACTIVE_SLOTS_ADDR = {CSR_IDX_ACTIVE, 2'b00};
   localparam int         STALL_LIMIT       = 3000;
   localparam int         HOLD_CYCLES       = 300;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata   = '0;   // [4:0] count, [12:5] slot_index, zero above
   logic [0:0]  req_tuser   = '0;   // [0] op
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [23:0] rsp_tdata;          // [7:0] granted_index, [16:8] free_slots, zero above
   logic [1:0]  rsp_tuser;          // [1:0] status
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int         mismatches;
   int         pending;
   bit         idle_on     = 1'b1;
   bit         hold_want   = 1'b0;
   bit         hold_taken  = 1'b0;
   int         hold_left   = 0;
   int         stall_cycles = 0;
   logic [7:0] granted_pool [$];

   always #6 clock = ~clock;

   descriptor_slot_allocator_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   slot_alloc_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_pready (csr_pready),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .mismatches (mismatches),
      .pending    (pending)
   );

   // Response side: random back-pressure, plus one long hold-off to fill the block.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_want && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left  = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  = hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on) begin
         rsp_tready <= ($urandom_range(99) >= 32);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Granted slots are remembered so that most releases name a busy slot.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready && rsp_tuser == ST_GRANT)
         granted_pool.push_back(rsp_tdata[7:0]);
   end

   // Watchdog on cycles in which no transaction completes anywhere.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Offers one request and returns at the edge where it is taken; tvalid stays high.
   task automatic offer_request(input logic op, input logic [4:0] cnt, input logic [7:0] slot);
      while (idle_on && $urandom_range(99) < 32) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {3'b000, slot, cnt};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Waits until every outstanding response has been seen, then lets the block settle.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_active_slots(input logic [8:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ACTIVE_SLOTS_ADDR;
      csr_pwdata  <= {23'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Mostly releases of granted slots and small allocations, with some malformed requests.
   task automatic random_request();
      int         roll;
      int         pick;
      logic [7:0] slot;
      logic [4:0] cnt;
      roll = $urandom_range(99);
      if (roll < 50 && granted_pool.size() > 0) begin
         pick = $urandom_range(granted_pool.size() - 1);
         slot = granted_pool[pick];
         granted_pool.delete(pick);
         offer_request(OP_RELEASE, 5'($urandom), slot);
      end else if (roll < 58) begin
         offer_request(OP_RELEASE, 5'($urandom), 8'($urandom));
      end else if (roll < 64) begin
         cnt = ($urandom_range(1) == 0) ? 5'd0 : 5'($urandom_range(31, 17));
         offer_request(OP_ALLOC, cnt, 8'($urandom));
      end else begin
         cnt = ($urandom_range(99) < 70) ? 5'($urandom_range(4, 1)) : 5'($urandom_range(16, 1));
         offer_request(OP_ALLOC, cnt, 8'($urandom));
      end
   endtask

   task automatic random_phase(input int items);
      for (int i = 0; i < items; i++) random_request();
      settle();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Refused counts, a full batch, gap filling and bad releases at the reset size.
      offer_request(OP_ALLOC, 5'd0, 8'hFF);
      offer_request(OP_ALLOC, 5'd31, 8'h00);
      offer_request(OP_ALLOC, 5'd17, 8'h00);
      offer_request(OP_ALLOC, 5'd16, 8'h00);
      offer_request(OP_ALLOC, 5'd1, 8'h00);
      offer_request(OP_RELEASE, 5'd31, 8'd5);
      offer_request(OP_RELEASE, 5'd0, 8'd5);
      offer_request(OP_RELEASE, 5'd0, 8'hFF);
      offer_request(OP_ALLOC, 5'd3, 8'hFF);
      offer_request(OP_RELEASE, 5'd0, 8'd0);
      offer_request(OP_ALLOC, 5'd15, 8'h00);
      settle();

      // Shrunk size with busy marks beyond it.
      write_active_slots(9'd8);
      offer_request(OP_ALLOC, 5'd1, 8'h00);
      offer_request(OP_RELEASE, 5'd0, 8'd20);
      offer_request(OP_RELEASE, 5'd0, 8'd3);
      offer_request(OP_ALLOC, 5'd2, 8'h00);
      offer_request(OP_ALLOC, 5'd1, 8'h00);
      settle();

      // A size of zero leaves no usable slot.
      write_active_slots(9'd0);
      offer_request(OP_ALLOC, 5'd1, 8'h00);
      offer_request(OP_RELEASE, 5'd0, 8'd0);
      settle();

      // An oversized value is clamped to the table size.
      write_active_slots(9'h1FF);
      offer_request(OP_RELEASE, 5'd0, 8'd20);
      settle();

      // The smallest legal size.
      write_active_slots(9'd1);
      offer_request(OP_RELEASE, 5'd0, 8'd0);
      offer_request(OP_ALLOC, 5'd1, 8'h00);
      settle();

      // Full table, with the long response hold-off at the start.
      write_active_slots(9'd256);
      hold_want = 1'b1;
      random_phase(28);

      write_active_slots(9'($urandom_range(255, 2)));
      random_phase(28);

      write_active_slots(9'd16);
      random_phase(28);

      // A stretch with no idling on either side.
      write_active_slots(9'd256);
      idle_on = 1'b0;
      random_phase(28);
      idle_on = 1'b1;

      write_active_slots(9'($urandom_range(511, 257)));
      random_phase(28);

      repeat (20) @(posedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
